// ----- design/dtad_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package dtad_pkg;
  localparam int MaxYear = 9999;
  localparam logic [23:0] DaysLimit = 24'(MaxYear * 365 + MaxYear / 4 - MaxYear / 100
                                          + MaxYear / 400);
  localparam int DaysPer400 = 146097;
  localparam int DaysPer4 = 1461;
  localparam int SecsPerHour = 3600;

  localparam logic OpSub = 1'b1;

  // days before the first of each month, plus one after February in a leap year
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic lp);
    logic [8:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    if (lp && m > 4'd2) d = d + 9'd1;
    return d;
  endfunction

  // y / 100 by reciprocal multiplication, exact for every 14-bit y
  function automatic logic [7:0] div100(input logic [13:0] y);
    logic [27:0] prod;
    prod = 28'(y) * 28'd10486;
    return prod[27:20];
  endfunction

  function automatic logic leap_of(input logic [13:0] y);
    logic [7:0] q;
    logic r4, r100, r400;
    q = div100(y);
    r4 = (y[1:0] == 2'd0);
    r100 = ((16'(q) * 16'd100) == 16'(y));
    r400 = r100 && (q[1:0] == 2'd0);
    return r4 && (!r100 || r400);
  endfunction
endpackage
`default_nettype wire

// ----- design/datetime_add_subtract_duration.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Proleptic Gregorian date/time plus or minus a duration of days, hours,
// minutes and seconds. Results before year 1 or after year 9999 raise
// out_of_range with all date/time fields zero. Pipeline of six register
// stages: an item can enter every cycle while the output is not stalled;
// the depth is set by the day-count split into 400/100/4/1-year periods.
// A stall at the output holds the whole pipeline.
module datetime_add_subtract_duration (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output wire        s_tready,
  // operation, year, month, day, hour, minute, second, span_days,
  // span_hours, span_minutes, span_seconds; zero fill to 80 bits
  input  wire [79:0] s_tdata,
  output wire        m_tvalid,
  input  wire        m_tready,
  // res_year, res_month, res_day, res_hour, res_minute, res_second,
  // out_of_range; zero fill to 48 bits
  output wire [47:0] m_tdata
);
  import dtad_pkg::*;

  logic adv;
  logic [5:0] v;
  assign adv = !v[5] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = v[5];

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else if (adv) v <= {v[4:0], s_tvalid};
  end

  // input fields
  logic        i_op;
  logic [13:0] i_yr;
  logic [3:0]  i_mo;
  logic [4:0]  i_dy, i_hr, i_sh;
  logic [5:0]  i_mi, i_se, i_sm, i_ss;
  logic [19:0] i_sd;
  assign i_op = s_tdata[0];
  assign i_yr = s_tdata[14:1];
  assign i_mo = s_tdata[18:15];
  assign i_dy = s_tdata[23:19];
  assign i_hr = s_tdata[28:24];
  assign i_mi = s_tdata[34:29];
  assign i_se = s_tdata[40:35];
  assign i_sd = s_tdata[60:41];
  assign i_sh = s_tdata[65:61];
  assign i_sm = s_tdata[71:66];
  assign i_ss = s_tdata[77:72];

  // stage 1: day and second parts of start and span
  logic        op1;
  logic [23:0] d1;      // start days before year, plus month/day
  logic [19:0] sd1;
  logic [17:0] s1, ss1; // seconds within day (may exceed a day)
  logic [13:0] p_c;
  logic [3:0]  mo_c;
  logic [7:0]  q100_c;
  logic [23:0] dby_c;
  always_comb begin
    p_c = (i_yr == 14'd0) ? 14'd0 : i_yr - 14'd1;
    mo_c = (i_mo > 4'd12) ? 4'd12 : ((i_mo == 4'd0) ? 4'd1 : i_mo);
    q100_c = div100(p_c);
    dby_c = 24'(p_c) * 24'd365 + 24'(p_c >> 2) - 24'(q100_c) + 24'(q100_c >> 2);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      op1 <= i_op;
      d1  <= dby_c + 24'(month_start(mo_c, leap_of(i_yr)))
           + ((i_dy == 5'd0) ? 24'd0 : 24'(i_dy - 5'd1));
      sd1 <= i_sd;
      s1  <= 18'(i_hr) * 18'd3600 + 18'(i_mi) * 18'd60 + 18'(i_se);
      ss1 <= 18'(i_sh) * 18'd3600 + 18'(i_sm) * 18'd60 + 18'(i_ss);
    end
  end

  // stage 2: combine, normalize seconds to [0,86400)
  logic signed [26:0] d2;
  logic [16:0] r2;
  logic signed [26:0] dd_c;
  logic signed [19:0] sec_c;
  function automatic void while_fix(inout logic signed [19:0] s,
                                    inout logic signed [26:0] d);
    for (int k = 0; k < 3; k++) begin
      if (s >= 20'sd86400) begin
        s = s - 20'sd86400;
        d = d + 27'sd1;
      end
    end
  endfunction
  always_comb begin
    sec_c = (op1 == OpSub) ? (20'sd0 + signed'({2'b0, s1}) - signed'({2'b0, ss1}))
                           : (signed'({2'b0, s1}) + signed'({2'b0, ss1}));
    dd_c = (op1 == OpSub) ? (signed'({3'b0, d1}) - signed'({7'b0, sd1}))
                          : (signed'({3'b0, d1}) + signed'({7'b0, sd1}));
    if (sec_c < 0) begin
      sec_c = sec_c + 20'sd86400;
      dd_c = dd_c - 27'sd1;
      if (sec_c < 0) begin
        sec_c = sec_c + 20'sd86400;
        dd_c = dd_c - 27'sd1;
      end
    end
    while_fix(sec_c, dd_c);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      d2 <= dd_c;
      r2 <= sec_c[16:0];
    end
  end

  // stage 3: range check, 400-year split
  logic        oor3;
  logic [22:0] dq3;   // days within 400-year period
  logic [4:0]  q4_3;
  logic [16:0] r3;
  logic [22:0] dpos_c;
  logic [4:0]  q_c;
  logic [22:0] qb_c;
  always_comb begin
    dpos_c = d2[22:0];
    q_c = 5'd0;
    qb_c = 23'd0;
    for (int k = 1; k <= 24; k++) begin
      if (dpos_c >= 23'(k * DaysPer400)) begin
        q_c = 5'(k);
        qb_c = 23'(k * DaysPer400);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      oor3 <= (d2 < 0) || (d2 >= signed'({3'b0, DaysLimit}));
      q4_3 <= q_c;
      dq3  <= dpos_c - qb_c;
      r3   <= r2;
    end
  end

  // stage 4: century and 4-year split
  logic        oor4;
  logic [13:0] y4;
  logic [10:0] d4;
  logic [16:0] r4;
  logic [1:0]  c_c;
  logic [17:0] dc_c;
  logic [4:0]  f_c;
  logic [17:0] fb_c;
  always_comb begin
    c_c = (dq3 >= 23'd109572) ? 2'd3 : (dq3 >= 23'd73048) ? 2'd2 :
          (dq3 >= 23'd36524) ? 2'd1 : 2'd0;
    dc_c = 18'(dq3 - 23'(c_c) * 23'd36524);
    f_c = 5'd0;
    fb_c = 18'd0;
    for (int k = 1; k <= 24; k++) begin
      if (dc_c >= 18'(k * DaysPer4)) begin
        f_c = 5'(k);
        fb_c = 18'(k * DaysPer4);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      oor4 <= oor3;
      y4 <= 14'd1 + 14'(q4_3) * 14'd400 + 14'(c_c) * 14'd100 + 14'(f_c) * 14'd4;
      d4 <= 11'(dc_c - fb_c);
      r4 <= r3;
    end
  end

  // stage 5: year within period, leap, hour of day
  logic        oor5, lp5;
  logic [13:0] y5;
  logic [8:0]  d5;
  logic [4:0]  hr5;
  logic [11:0] rh5;   // seconds within the hour
  logic [1:0]  n_c;
  logic [13:0] ynew_c;
  logic [4:0]  h_c;
  logic [16:0] hb_c;
  always_comb begin
    n_c = (d4 >= 11'd1095) ? 2'd3 : (d4 >= 11'd730) ? 2'd2 :
          (d4 >= 11'd365) ? 2'd1 : 2'd0;
    ynew_c = y4 + 14'(n_c);
    h_c = 5'd0;
    hb_c = 17'd0;
    for (int k = 1; k <= 23; k++) begin
      if (r4 >= 17'(k * SecsPerHour)) begin
        h_c = 5'(k);
        hb_c = 17'(k * SecsPerHour);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      oor5 <= oor4;
      y5 <= ynew_c;
      lp5 <= leap_of(ynew_c);
      d5 <= 9'(d4 - 11'(n_c) * 11'd365);
      hr5 <= h_c;
      rh5 <= 12'(r4 - hb_c);
    end
  end

  // stage 6: month/day, minute and second
  logic [47:0] out6;
  logic [3:0]  m_c;
  logic [8:0]  dm_c;
  logic [24:0] mq_c;
  logic [5:0]  mn_c, sc_c;
  always_comb begin
    m_c = 4'd1;
    for (int k = 2; k <= 12; k++) begin
      if (d5 >= month_start(4'(k), lp5)) m_c = 4'(k);
    end
    dm_c = d5 - month_start(m_c, lp5);
    // divide by 60 through the reciprocal, exact below one hour
    mq_c = 25'(rh5) * 25'd4370;
    mn_c = mq_c[23:18];
    sc_c = 6'(rh5 - 12'(mn_c) * 12'd60);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      if (oor5) out6 <= 48'(1) << 40;
      else out6 <= {7'd0, 1'b0, sc_c, mn_c, hr5, 5'(dm_c + 9'd1), m_c, y5};
    end
  end
  assign m_tdata = out6;

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[40] |-> m_tdata[39:0] == 40'd0) else $error("oor");
  a_month: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[40] |-> m_tdata[17:14] >= 4'd1 && m_tdata[17:14] <= 4'd12)
    else $error("month");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("hold");
endmodule
`default_nettype wire
